/* design/rotation_window_pool_defines.svh */
// assertion macros for the rotation window pool checker
`ifndef ROTATION_WINDOW_POOL_DEFINES_SVH
`define ROTATION_WINDOW_POOL_DEFINES_SVH

// implication to the next cycle, off while reset is high
`define RWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication to the next cycle, checked through reset as well
`define RWP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rwp_pkg.sv */
// ----------------------------------------------------------------------------
// rwp_pkg
// shared types and constants of the rotation window pool: register
// indexes, size limits and the request record passed from front to back
// ----------------------------------------------------------------------------
package rwp_pkg;

  localparam int ROT_W      = 16;
  localparam int COL_W      = 8;
  localparam int AREA_W     = 9;
  localparam int FLIP_W     = 9;
  localparam int CFG_W      = 16;
  localparam int IDX_W      = 3;
  localparam int MAX_WINDOW = 16;
  localparam int MAX_OUT    = 256;

  typedef enum logic [IDX_W-1:0] {
    REG_GROUP_ORDER = 3'd0,
    REG_WINDOW_ROWS = 3'd1,
    REG_WINDOW_COLS = 3'd2,
    REG_OUT_ROWS    = 3'd3,
    REG_OUT_COLS    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [ROT_W-1:0]  rot;
    logic              flip;
    logic [COL_W-1:0]  col;
    logic              clear;
    logic              emit;
    logic              fend;
    logic              first;
    logic [ROT_W-1:0]  n;
    logic [AREA_W-1:0] area;
  } rwp_req_t;

endpackage

/* design/rwp_fifo.sv */
// ----------------------------------------------------------------------------
// rwp_fifo
// two-entry request queue between the front classifier and the back end
// ----------------------------------------------------------------------------
module rwp_fifo import rwp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rwp_req_t push_req,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output rwp_req_t head_req
);

  rwp_req_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_req   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_req;
  end

endmodule

/* design/rwp_front.sv */
// ----------------------------------------------------------------------------
// rwp_front
// accepts pixels, tracks the raster position, latches the frame geometry
// at frame start and classifies each pixel for the back end
// ----------------------------------------------------------------------------
module rwp_front import rwp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ROT_W-1:0]  cfg_group_order,
  input  logic [4:0]        cfg_window_rows,
  input  logic [4:0]        cfg_window_cols,
  input  logic [8:0]        cfg_out_rows,
  input  logic [8:0]        cfg_out_cols,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ROT_W-1:0]  rotation_in,
  input  logic              flip_in,
  input  logic              q_full,
  output logic              push,
  output rwp_req_t          push_req
);

  logic [3:0]        row_in_window;
  logic [3:0]        col_in_window;
  logic [COL_W-1:0]  out_col_index;
  logic [7:0]        out_row_index;

  logic [ROT_W-1:0]  lat_n;
  logic [4:0]        lat_wr;
  logic [4:0]        lat_wc;
  logic [8:0]        lat_or;
  logic [8:0]        lat_oc;
  logic [AREA_W-1:0] lat_area;

  logic              frame_start;
  logic [4:0]        clamp_wr;
  logic [4:0]        clamp_wc;
  logic [8:0]        clamp_or;
  logic [8:0]        clamp_oc;
  logic [9:0]        clamp_area;
  logic [ROT_W-1:0]  cur_n;
  logic [4:0]        cur_wr;
  logic [4:0]        cur_wc;
  logic [8:0]        cur_or;
  logic [8:0]        cur_oc;
  logic [AREA_W-1:0] cur_area;
  logic              col_last;
  logic              row_last;
  logic              ocol_last;
  logic              orow_last;

  always_comb begin
    if (cfg_window_rows == 5'd0)                 clamp_wr = 5'd1;
    else if (cfg_window_rows > 5'(MAX_WINDOW))   clamp_wr = 5'(MAX_WINDOW);
    else                                         clamp_wr = cfg_window_rows;
    if (cfg_window_cols == 5'd0)                 clamp_wc = 5'd1;
    else if (cfg_window_cols > 5'(MAX_WINDOW))   clamp_wc = 5'(MAX_WINDOW);
    else                                         clamp_wc = cfg_window_cols;
    if (cfg_out_rows == 9'd0)                    clamp_or = 9'd1;
    else if (cfg_out_rows > 9'(MAX_OUT))         clamp_or = 9'(MAX_OUT);
    else                                         clamp_or = cfg_out_rows;
    if (cfg_out_cols == 9'd0)                    clamp_oc = 9'd1;
    else if (cfg_out_cols > 9'(MAX_OUT))         clamp_oc = 9'(MAX_OUT);
    else                                         clamp_oc = cfg_out_cols;
    clamp_area = {5'd0, clamp_wr} * {5'd0, clamp_wc};
  end

  assign frame_start = (row_in_window == 4'd0) && (col_in_window == 4'd0) &&
                       (out_col_index == '0) && (out_row_index == 8'd0);

  assign cur_n    = frame_start ? cfg_group_order : lat_n;
  assign cur_wr   = frame_start ? clamp_wr : lat_wr;
  assign cur_wc   = frame_start ? clamp_wc : lat_wc;
  assign cur_or   = frame_start ? clamp_or : lat_or;
  assign cur_oc   = frame_start ? clamp_oc : lat_oc;
  assign cur_area = frame_start ? clamp_area[AREA_W-1:0] : lat_area;

  assign col_last  = ({1'b0, col_in_window} == (cur_wc - 5'd1));
  assign row_last  = ({1'b0, row_in_window} == (cur_wr - 5'd1));
  assign ocol_last = ({1'b0, out_col_index} == (cur_oc - 9'd1));
  assign orow_last = ({1'b0, out_row_index} == (cur_or - 9'd1));

  assign in_ready = ~q_full;
  assign push     = in_valid & in_ready;

  always_comb begin
    push_req.rot   = rotation_in;
    push_req.flip  = flip_in;
    push_req.col   = out_col_index;
    push_req.clear = (row_in_window == 4'd0) && (col_in_window == 4'd0);
    push_req.emit  = row_last && col_last;
    push_req.fend  = ocol_last && orow_last;
    push_req.first = frame_start;
    push_req.n     = cur_n;
    push_req.area  = cur_area;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_in_window <= 4'd0;
      col_in_window <= 4'd0;
      out_col_index <= '0;
      out_row_index <= 8'd0;
    end else if (push) begin
      if (col_last) begin
        col_in_window <= 4'd0;
        if (ocol_last) begin
          out_col_index <= '0;
          if (row_last) begin
            row_in_window <= 4'd0;
            out_row_index <= orow_last ? 8'd0 : out_row_index + 8'd1;
          end else begin
            row_in_window <= row_in_window + 4'd1;
          end
        end else begin
          out_col_index <= out_col_index + COL_W'(1);
        end
      end else begin
        col_in_window <= col_in_window + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && frame_start) begin
      lat_n    <= cfg_group_order;
      lat_wr   <= clamp_wr;
      lat_wc   <= clamp_wc;
      lat_or   <= clamp_or;
      lat_oc   <= clamp_oc;
      lat_area <= clamp_area[AREA_W-1:0];
    end
  end

endmodule

/* design/rwp_div.sv */
// ----------------------------------------------------------------------------
// rwp_div
// restoring divider, one quotient bit per cycle; the upper half of the
// dividend must be below the divisor so the quotient fits in ROT_W bits
// ----------------------------------------------------------------------------
module rwp_div import rwp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2*ROT_W-1:0] dividend,
  input  logic [ROT_W-1:0]   divisor,
  output logic               done,
  output logic [ROT_W-1:0]   quotient
);

  logic               busy;
  logic [3:0]         cnt;
  logic [ROT_W-1:0]   rem;
  logic [ROT_W-1:0]   dvd_lo;
  logic [ROT_W-1:0]   dvs;
  logic [ROT_W:0]     trial;
  logic [ROT_W:0]     diff;
  logic               ge;

  assign trial    = {rem, dvd_lo[ROT_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign quotient = dvd_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(ROT_W - 1);
      end else if (busy) begin
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

  // quotient bits shift into the low end as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= dividend[2*ROT_W-1:ROT_W];
      dvd_lo <= dividend[ROT_W-1:0];
      dvs    <= divisor;
    end else if (busy) begin
      rem    <= ge ? diff[ROT_W-1:0] : trial[ROT_W-1:0];
      dvd_lo <= {dvd_lo[ROT_W-2:0], ge};
    end
  end

endmodule

/* design/rwp_back.sv */
// ----------------------------------------------------------------------------
// rwp_back
// back end: window weight and rotation scaling on a shared divider,
// per-column accumulation and the registered result stage
// ----------------------------------------------------------------------------
module rwp_back import rwp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  rwp_req_t          head_req,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROT_W-1:0]  rotation_sum,
  output logic              flip_major,
  output logic              frame_end
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_WDIV = 6'b000010,
    B_MUL  = 6'b000100,
    B_SGO  = 6'b001000,
    B_SDIV = 6'b010000,
    B_ACC  = 6'b100000
  } back_state_t;

  back_state_t        state;
  back_state_t        state_next;

  logic [ROT_W-1:0]   rot_mem  [MAX_OUT];
  logic [FLIP_W-1:0]  flip_mem [MAX_OUT];
  logic [ROT_W-1:0]   rd_rot;
  logic [FLIP_W-1:0]  rd_flip;

  logic [ROT_W-1:0]   weight;
  logic [2*ROT_W-1:0] prod;
  logic [ROT_W-1:0]   scaled;

  logic               div_start;
  logic [2*ROT_W-1:0] div_dividend;
  logic [ROT_W-1:0]   div_divisor;
  logic               div_done;
  logic [ROT_W-1:0]   div_quotient;

  logic [ROT_W:0]     sum_wide;
  logic [ROT_W-1:0]   sum_sat;
  logic [FLIP_W-1:0]  flip_new;
  logic               out_free;
  logic               commit;

  rwp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_free = ~out_valid | out_ready;
  assign commit   = (state == B_ACC) && (~head_req.emit || out_free);
  assign pop      = commit;

  always_comb begin
    sum_wide = {1'b0, (head_req.clear ? {ROT_W{1'b0}} : rd_rot)} + {1'b0, scaled};
    sum_sat  = sum_wide[ROT_W] ? '1 : sum_wide[ROT_W-1:0];
    flip_new = (head_req.clear ? '0 : rd_flip) + {{(FLIP_W-1){1'b0}}, head_req.flip};
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod;
    div_divisor  = head_req.n;
    if (state == B_IDLE && head_valid && head_req.first) begin
      div_start    = 1'b1;
      div_dividend = {{ROT_W{1'b0}}, head_req.n};
      div_divisor  = {{(ROT_W-AREA_W){1'b0}}, head_req.area};
    end else if (state == B_SGO && head_req.n != '0) begin
      div_start = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (head_valid) state_next = head_req.first ? B_WDIV : B_MUL;
      end
      B_WDIV: begin
        if (div_done) state_next = B_MUL;
      end
      B_MUL:  state_next = B_SGO;
      B_SGO:  state_next = (head_req.n == '0) ? B_ACC : B_SDIV;
      B_SDIV: begin
        if (div_done) state_next = B_ACC;
      end
      B_ACC: begin
        if (commit) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit && head_req.emit) out_valid <= 1'b1;
      else if (out_ready)          out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_WDIV && div_done) weight <= div_quotient;
    if (state == B_MUL) begin
      prod    <= {{ROT_W{1'b0}}, head_req.rot} * {{ROT_W{1'b0}}, weight};
      rd_rot  <= rot_mem[head_req.col];
      rd_flip <= flip_mem[head_req.col];
    end
    if (state == B_SGO)                   scaled <= '0;
    else if (state == B_SDIV && div_done) scaled <= div_quotient;
    if (commit) begin
      rot_mem[head_req.col]  <= sum_sat;
      flip_mem[head_req.col] <= flip_new;
    end
    if (commit && head_req.emit) begin
      rotation_sum <= sum_sat;
      flip_major   <= (flip_new > {1'b0, head_req.area[AREA_W-1:1]});
      frame_end    <= head_req.fend;
    end
  end

endmodule

/* design/rotation_window_pool.sv */
// ----------------------------------------------------------------------------
// rotation_window_pool
// sum pooling of rotation values with a flip majority vote over
// non-overlapping windows of a raster-order pixel stream
// ----------------------------------------------------------------------------
// A pixel takes one pass through a 16-step restoring divider to scale
// the rotation, plus the multiply, a memory read and the accumulate
// write. The first pixel of each frame also waits while the same divider
// works out the window weight from the latched geometry. With a group
// order of zero the scaling division is skipped. A two-entry queue lets
// the input accept pixels while the back end is busy, and results sit in
// an output register until taken. Register writes take effect at the
// next frame start.
module rotation_window_pool import rwp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ROT_W-1:0]  rotation_in,
  input  logic              flip_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROT_W-1:0]  rotation_sum,
  output logic              flip_major,
  output logic              frame_end
);

  logic [ROT_W-1:0] group_order;
  logic [4:0]       window_rows;
  logic [4:0]       window_cols;
  logic [8:0]       out_rows;
  logic [8:0]       out_cols;

  logic             q_full;
  logic             push;
  rwp_req_t         push_req;
  logic             pop;
  logic             head_valid;
  rwp_req_t         head_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_order <= 16'd8;
      window_rows <= 5'd2;
      window_cols <= 5'd2;
      out_rows    <= 9'd8;
      out_cols    <= 9'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_ORDER: group_order <= cfg_data;
        REG_WINDOW_ROWS: window_rows <= cfg_data[4:0];
        REG_WINDOW_COLS: window_cols <= cfg_data[4:0];
        REG_OUT_ROWS:    out_rows    <= cfg_data[8:0];
        REG_OUT_COLS:    out_cols    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  rwp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_group_order (group_order),
    .cfg_window_rows (window_rows),
    .cfg_window_cols (window_cols),
    .cfg_out_rows    (out_rows),
    .cfg_out_cols    (out_cols),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rotation_in     (rotation_in),
    .flip_in         (flip_in),
    .q_full          (q_full),
    .push            (push),
    .push_req        (push_req)
  );

  rwp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  rwp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_req     (head_req),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rotation_sum (rotation_sum),
    .flip_major   (flip_major),
    .frame_end    (frame_end)
  );

endmodule

/* design/rwp_checker.sv */
// ----------------------------------------------------------------------------
// rwp_checker
// port-level checks of the rotation window pool, bound to the top level
// ----------------------------------------------------------------------------
`include "rotation_window_pool_defines.svh"

module rwp_checker import rwp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [ROT_W-1:0]  rotation_in,
  input logic              flip_in,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ROT_W-1:0]  rotation_sum,
  input logic              flip_major,
  input logic              frame_end
);

  // a stalled result holds
  `RWP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rotation_sum) && $stable(flip_major) && $stable(frame_end), "result changed while stalled")

  // reset leaves an empty queue and no result
  `RWP_ASSERT_ALWAYS(a_reset_clean, rst, !out_valid && in_ready, "state not clear after reset")

  // a waiting pixel request holds
  `RWP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable({rotation_in, flip_in}), "pixel changed while waiting")

  // a shown result has known fields
  `RWP_ASSERT_NEXT(a_out_known, 1'b1, !out_valid || !$isunknown({rotation_sum, flip_major, frame_end}), "unknown result")

endmodule

bind rotation_window_pool rwp_checker u_rwp_checker (.*);
